// File: rtl/btlp_pkg.sv
// Package with the shared constants, types and reset tables of the LED PWM bank.
`default_nettype none
package btlp_pkg;

	localparam int CHANNELS = 4;
	localparam int SEL_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DUTY_W   = 6;
	localparam int PER_W    = 6;
	localparam int DEB_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 16;
	localparam int LED_W    = 4;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd300;
	localparam logic [PER_W-1:0] PWM_RESET      = 6'd10;
	localparam logic [PER_W-1:0] BLINK_RESET    = 6'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_PWM      = 2'd1,
		REG_BLINK    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              duty_we;
		logic [DUTY_W-1:0] duty_val;
	} ctl_t;

	function automatic logic [DUTY_W-1:0] reset_duty(input int c);
		logic [DUTY_W-1:0] d;
		case (c)
			0: d = 6'd5;
			1: d = 6'd2;
			2: d = 6'd8;
			default: d = '0;
		endcase
		return d;
	endfunction

	function automatic logic [PER_W-1:0] reset_period(input int c);
		return (c == 0) ? BLINK_RESET : PWM_RESET;
	endfunction

endpackage
`default_nettype wire

// File: rtl/btlp_ctrl.sv
// Button debounce, channel selection and duty adjustment.
`default_nettype none
module btlp_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          adv,
	input  wire                          next_press,
	input  wire                          raise_press,
	input  wire [btlp_pkg::DEB_W-1:0]    deb_limit,
	input  wire [btlp_pkg::PER_W-1:0]    pwm_len,
	input  wire [btlp_pkg::DUTY_W-1:0]   duty_cur,
	output logic [btlp_pkg::SEL_W-1:0]   sel,
	output btlp_pkg::ctl_t               ctl
);

	logic [btlp_pkg::DEB_W-1:0] next_elapsed_q;
	logic [btlp_pkg::DEB_W-1:0] raise_elapsed_q;
	logic [btlp_pkg::SEL_W-1:0] selection_q;

	logic                          next_ok;
	logic                          raise_ok;
	logic [btlp_pkg::SEL_W-1:0]    sel_new;
	logic [btlp_pkg::DUTY_W:0]     duty_inc;
	logic [btlp_pkg::DEB_W-1:0]    next_base;
	logic [btlp_pkg::DEB_W-1:0]    raise_base;

	always_comb begin
		next_ok = next_press && (next_elapsed_q >= deb_limit);
		if (next_ok) begin
			if (selection_q == btlp_pkg::SEL_W'(btlp_pkg::CHANNELS - 1))
				sel_new = '0;
			else
				sel_new = selection_q + btlp_pkg::SEL_W'(1);
		end else begin
			sel_new = selection_q;
		end
	end

	assign sel = sel_new;

	always_comb begin
		// A bounced select press also drops the raise press of the same word.
		raise_ok = raise_press && !(next_press && !next_ok)
			&& (raise_elapsed_q >= deb_limit);
		duty_inc = {1'b0, duty_cur} + 7'd1;
		ctl.duty_we  = raise_ok;
		ctl.duty_val = (duty_inc > {1'b0, pwm_len}) ? '0
			: duty_inc[btlp_pkg::DUTY_W-1:0];
		next_base  = next_ok  ? '0 : next_elapsed_q;
		raise_base = raise_ok ? '0 : raise_elapsed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_elapsed_q  <= '0;
			raise_elapsed_q <= '0;
			selection_q     <= '0;
		end else if (adv) begin
			selection_q     <= sel_new;
			next_elapsed_q  <= (&next_base)  ? next_base
				: next_base + btlp_pkg::DEB_W'(1);
			raise_elapsed_q <= (&raise_base) ? raise_base
				: raise_base + btlp_pkg::DEB_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: rtl/btlp_chan_bank.sv
// Per-channel duty settings, phase counters and PWM compare.
`default_nettype none
module btlp_chan_bank (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              adv,
	input  wire [btlp_pkg::SEL_W-1:0]        sel,
	input  wire btlp_pkg::ctl_t              ctl,
	input  wire [btlp_pkg::PER_W-1:0]        pwm_len,
	input  wire [btlp_pkg::PER_W-1:0]        blink_len,
	output logic [btlp_pkg::DUTY_W-1:0]      duty_cur,
	output logic [btlp_pkg::CHANNELS-1:0]    led
);

	logic [btlp_pkg::DUTY_W-1:0] duty_q   [btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W-1:0]  phase_q  [btlp_pkg::CHANNELS];
	logic [btlp_pkg::DUTY_W-1:0] ld_duty_q[btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W-1:0]  ld_per_q [btlp_pkg::CHANNELS];

	logic [btlp_pkg::DUTY_W-1:0] duty_new [btlp_pkg::CHANNELS];
	logic [btlp_pkg::DUTY_W-1:0] duty_eff [btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W-1:0]  per_eff  [btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W:0]    phase_inc[btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W-1:0]  phase_nxt[btlp_pkg::CHANNELS];
	logic [btlp_pkg::PER_W-1:0]  per_sel  [btlp_pkg::CHANNELS];

	assign duty_cur = duty_q[sel];

	always_comb begin
		for (int c = 0; c < btlp_pkg::CHANNELS; c++) begin
			duty_new[c] = (ctl.duty_we && (sel == btlp_pkg::SEL_W'(c)))
				? ctl.duty_val : duty_q[c];
			per_sel[c] = (sel == btlp_pkg::SEL_W'(c)) ? blink_len : pwm_len;
			if (per_sel[c] == '0)
				per_sel[c] = 6'd1;
			// A cycle starts at phase zero and takes the current settings.
			if (phase_q[c] == '0) begin
				duty_eff[c] = duty_new[c];
				per_eff[c]  = per_sel[c];
			end else begin
				duty_eff[c] = ld_duty_q[c];
				per_eff[c]  = ld_per_q[c];
			end
			led[c] = phase_q[c] < duty_eff[c];
			phase_inc[c] = {1'b0, phase_q[c]} + 7'd1;
			phase_nxt[c] = (phase_inc[c] >= {1'b0, per_eff[c]}) ? '0
				: phase_inc[c][btlp_pkg::PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < btlp_pkg::CHANNELS; c++) begin
				duty_q[c]    <= btlp_pkg::reset_duty(c);
				ld_duty_q[c] <= btlp_pkg::reset_duty(c);
				ld_per_q[c]  <= btlp_pkg::reset_period(c);
				phase_q[c]   <= '0;
			end
		end else if (adv) begin
			for (int c = 0; c < btlp_pkg::CHANNELS; c++) begin
				duty_q[c]    <= duty_new[c];
				ld_duty_q[c] <= duty_eff[c];
				ld_per_q[c]  <= per_eff[c];
				phase_q[c]   <= phase_nxt[c];
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/button_tuned_led_pwm_bank.sv
// Top level of the button-tuned LED PWM bank: input stage, control, channels, output register.
//
// Each input word is one millisecond tick carrying the press flags of the select and duty
// buttons; each tick gives exactly one output word with the lit LEDs, the selected channel
// and its duty. A word passes through an input register, the update logic and an output
// register; a new word is taken every cycle while the output is being drained.
// Configuration registers: 0 debounce ticks, 1 PWM period, 2 blink period; write them
// only while no word is in flight.
`default_nettype none
module button_tuned_led_pwm_bank (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire [btlp_pkg::IN_W-1:0]        s_tdata,  // next_press, raise_press
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [btlp_pkg::OUT_W-1:0]      m_tdata,  // led_on[3:0], selected_channel[1:0],
	                                                  // selected_duty[5:0]
	input  wire                             cfg_we,
	input  wire [btlp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire [btlp_pkg::CFG_W-1:0]       cfg_data
);

	logic [btlp_pkg::DEB_W-1:0] debounce_q;
	logic [btlp_pkg::PER_W-1:0] pwm_q;
	logic [btlp_pkg::PER_W-1:0] blink_q;

	logic valid_s1;
	logic next_s1;
	logic raise_s1;
	logic adv;

	btlp_pkg::ctl_t                 ctl;
	logic [btlp_pkg::SEL_W-1:0]     sel;
	logic [btlp_pkg::DUTY_W-1:0]    duty_cur;
	logic [btlp_pkg::CHANNELS-1:0]  led;
	logic [btlp_pkg::CHANNELS+3:0]  led_pad;
	logic [btlp_pkg::SEL_W+1:0]     sel_pad;
	logic [btlp_pkg::DUTY_W-1:0]    sel_duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= btlp_pkg::DEBOUNCE_RESET;
			pwm_q      <= btlp_pkg::PWM_RESET;
			blink_q    <= btlp_pkg::BLINK_RESET;
		end else if (cfg_we) begin
			case (btlp_pkg::cfg_reg_t'(cfg_idx))
				btlp_pkg::REG_DEBOUNCE: debounce_q <= cfg_data;
				btlp_pkg::REG_PWM:      pwm_q      <= cfg_data[btlp_pkg::PER_W-1:0];
				btlp_pkg::REG_BLINK:    blink_q    <= cfg_data[btlp_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	// The held word moves on whenever the output register is free or being emptied.
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			next_s1  <= s_tdata[0];
			raise_s1 <= s_tdata[1];
		end
	end

	btlp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.next_press  (next_s1),
		.raise_press (raise_s1),
		.deb_limit   (debounce_q),
		.pwm_len     (pwm_q),
		.duty_cur    (duty_cur),
		.sel         (sel),
		.ctl         (ctl)
	);

	btlp_chan_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.sel       (sel),
		.ctl       (ctl),
		.pwm_len   (pwm_q),
		.blink_len (blink_q),
		.duty_cur  (duty_cur),
		.led       (led)
	);

	assign led_pad  = {4'b0000, led};
	assign sel_pad  = {2'b00, sel};
	assign sel_duty = ctl.duty_we ? ctl.duty_val : duty_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {4'b0000, sel_duty, sel_pad[1:0], led_pad[btlp_pkg::LED_W-1:0]};
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("processed word did not reach the output register");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |=> valid_s1)
		else $error("held input word lost during an output stall");

	a_duty_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.duty_we |-> (ctl.duty_val <= pwm_q))
		else $error("new duty exceeds the PWM period");

endmodule
`default_nettype wire
